FILE: rtl/fshg_pkg.sv
// Shared types and constants for the feeder stall and heat gate.
package fshg_pkg;

    // Fixed-point steps in Q16.16: 3.6 units forward, 1.8 units reverse
    localparam logic signed [32:0] STEP_Q16    = 33'sd235930;
    localparam logic signed [32:0] REVERSE_Q16 = 33'sd117965;

    localparam logic [9:0] LOCAL_HEAT_MAX = 10'd1023;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STALL_MEAN_LIMIT = 3'd0,
        CFG_STALL_HOLD       = 3'd1,
        CFG_HEAT_CEILING     = 3'd2,
        CFG_HEAT_RESERVE     = 3'd3,
        CFG_HEAT_PER_SHOT    = 3'd4,
        CFG_COOL_STEP        = 3'd5,
        CFG_COOL_INTERVAL    = 3'd6
    } cfg_idx_t;

    // Shot request codes
    localparam logic [1:0] REQ_SINGLE     = 2'd1;
    localparam logic [1:0] REQ_CONTINUOUS = 2'd2;

    typedef struct packed {
        logic [14:0] stall_mean_limit;
        logic [7:0]  stall_hold;
        logic [15:0] heat_ceiling;
        logic [15:0] heat_reserve;
        logic [7:0]  heat_per_shot;
        logic [7:0]  cool_step;
        logic [7:0]  cool_interval;
    } cfg_t;

    // Input transaction, last declared field in the lowest bits
    typedef struct packed {
        logic [4:0]         pad;
        logic [15:0]        referee_heat;
        logic               referee_present;
        logic [7:0]         shot_period;
        logic [1:0]         shot_request;
        logic signed [31:0] setpoint_now;
        logic signed [31:0] position_error;
        logic signed [31:0] position;
        logic signed [15:0] current_sample;
    } s_item_t;

    // Result transaction, last declared field in the lowest bits
    typedef struct packed {
        logic [4:0]         pad;
        logic [15:0]        heat_in_use;
        logic               shot_fired;
        logic               stall_locked;
        logic               setpoint_write;
        logic signed [31:0] setpoint_out;
    } m_item_t;

    // Stall detector status for the tick being processed
    typedef struct packed {
        logic trip;   // stall detected this tick, reverse commanded
        logic flag;   // stall flag after this tick
    } stall_stat_t;

    // Heat gate status for the tick being processed
    typedef struct packed {
        logic        fired;
        logic [15:0] heat;
    } heat_stat_t;

endpackage

FILE: rtl/feeder_stall_and_heat_gate.sv
// Feeder stall detector and heat-gated shot stepper, top level.
//
// Usage: one input transaction per control tick on the s_ channel carries the
// current sample, position, position error, setpoint, shot request and
// referee heat. For each one the block returns exactly one result on the m_
// channel: new setpoint, write strobe, stall flag, shot flag and heat used.
// Configuration registers are written through cfg_we/cfg_index/cfg_data while
// no transaction is in flight; writes to unknown indexes are dropped.
//
// The input register feeds the window sum, stall and heat logic, which load the
// result register when it is free; m_tvalid rises when that register loads.
// Every state update is applied at the edge that loads the result, so while
// results are taken a new input transaction is accepted every cycle and
// throughput is one per cycle.
//
// Reset clears the current window, running sum, stall flag, all counters and
// the local heat, and loads the register defaults. When m_tready is low the
// result register holds and the input register still takes one transaction,
// then s_tready drops until the result is taken.
module feeder_stall_and_heat_gate #(
    parameter int WINDOW = 10
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // current_sample, position, position_error, setpoint_now, shot_request,
    // shot_period, referee_present, referee_heat, zero pad
    input  logic [143:0]                     s_tdata,
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // setpoint_out, setpoint_write, stall_locked, shot_fired, heat_in_use,
    // zero pad
    output logic [55:0]                      m_tdata,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [fshg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fshg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    fshg_pkg::cfg_t        cfg_reg;
    fshg_pkg::s_item_t     in_reg;
    logic                  in_valid_reg;
    fshg_pkg::m_item_t     out_reg, out_next;
    logic                  out_valid_reg;
    logic                  advance;
    logic                  s_fire;
    logic                  perr_small;
    fshg_pkg::stall_stat_t stall_stat;
    fshg_pkg::heat_stat_t  heat_stat;
    logic signed [32:0]    fwd_sum, rev_sum;
    logic signed [31:0]    fwd_sat, rev_sat;

    // Handshake: the compute stage moves when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stall_mean_limit <= 15'd9500;
            cfg_reg.stall_hold       <= 8'd25;
            cfg_reg.heat_ceiling     <= 16'd320;
            cfg_reg.heat_reserve     <= 16'd50;
            cfg_reg.heat_per_shot    <= 8'd10;
            cfg_reg.cool_step        <= 8'd10;
            cfg_reg.cool_interval    <= 8'd25;
        end else if (cfg_we) begin
            case (fshg_pkg::cfg_idx_t'(cfg_index))
                fshg_pkg::CFG_STALL_MEAN_LIMIT: cfg_reg.stall_mean_limit <= cfg_data[14:0];
                fshg_pkg::CFG_STALL_HOLD:       cfg_reg.stall_hold       <= cfg_data[7:0];
                fshg_pkg::CFG_HEAT_CEILING:     cfg_reg.heat_ceiling     <= cfg_data;
                fshg_pkg::CFG_HEAT_RESERVE:     cfg_reg.heat_reserve     <= cfg_data;
                fshg_pkg::CFG_HEAT_PER_SHOT:    cfg_reg.heat_per_shot    <= cfg_data[7:0];
                fshg_pkg::CFG_COOL_STEP:        cfg_reg.cool_step        <= cfg_data[7:0];
                fshg_pkg::CFG_COOL_INTERVAL:    cfg_reg.cool_interval    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg <= fshg_pkg::s_item_t'(s_tdata);
        end
    end

    fshg_stall_det #(
        .WINDOW (WINDOW)
    ) u_stall (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .sample     (in_reg.current_sample),
        .mean_limit (cfg_reg.stall_mean_limit),
        .hold       (cfg_reg.stall_hold),
        .stat       (stall_stat)
    );

    // |position_error| below one shot step
    assign perr_small = (in_reg.position_error < 32'sd235930) &&
                        (in_reg.position_error > -32'sd235930);

    fshg_heat_gate u_heat (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .cfg             (cfg_reg),
        .shot_request    (in_reg.shot_request),
        .shot_period     (in_reg.shot_period),
        .referee_present (in_reg.referee_present),
        .referee_heat    (in_reg.referee_heat),
        .stall_now       (stall_stat.flag),
        .perr_small      (perr_small),
        .stat            (heat_stat)
    );

    // Saturating setpoint step forward and reverse
    assign fwd_sum = 33'(in_reg.setpoint_now) + fshg_pkg::STEP_Q16;
    assign rev_sum = 33'(in_reg.position) - fshg_pkg::REVERSE_Q16;
    assign fwd_sat = (fwd_sum[32] != fwd_sum[31]) ?
                     (fwd_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : fwd_sum[31:0];
    assign rev_sat = (rev_sum[32] != rev_sum[31]) ?
                     (rev_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : rev_sum[31:0];

    // Result assembly
    always_comb begin
        out_next                = '0;
        out_next.setpoint_out   = in_reg.setpoint_now;
        if (heat_stat.fired) begin
            out_next.setpoint_out = fwd_sat;
        end else if (stall_stat.trip) begin
            out_next.setpoint_out = rev_sat;
        end
        out_next.setpoint_write = heat_stat.fired || stall_stat.trip;
        out_next.stall_locked   = stall_stat.flag;
        out_next.shot_fired     = heat_stat.fired;
        out_next.heat_in_use    = heat_stat.heat;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    // A shot is never commanded while the stall flag is set
    a_no_shot_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg.shot_fired && out_reg.stall_locked))
        else $error("shot fired while stalled");

    // Every shot comes with a setpoint write, as does every reverse; only shots are asserted
    a_shot_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.shot_fired |-> out_reg.setpoint_write)
        else $error("shot without setpoint write");

    // A held result blocks the compute stage
    a_hold_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !advance)
        else $error("result overwritten while stalled");

    // A stall trip always raises the flag and blocks the shot
    a_trip_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && stall_stat.trip |-> stall_stat.flag && !heat_stat.fired)
        else $error("stall trip without flag");

endmodule

FILE: rtl/fshg_stall_det.sv
// Current magnitude window, running sum and stall flag with hold counter.
module fshg_stall_det #(
    parameter int WINDOW = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic signed [15:0]    sample,
    input  logic [14:0]           mean_limit,
    input  logic [7:0]            hold,
    output fshg_pkg::stall_stat_t stat
);
    localparam int SUM_W = $clog2(WINDOW * 32768 + 1);

    logic [16:0]      win_reg [WINDOW];
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             flag_reg, flag_next;
    logic [7:0]       cnt_reg, cnt_next;
    logic [16:0]      mag;
    logic [SUM_W-1:0] thr;
    logic             trip;

    // Magnitude of the new sample, 17 bits to hold 32768
    assign mag      = sample[15] ? (17'd0 - {sample[15], sample}) : {1'b0, sample};
    assign sum_next = sum_reg - SUM_W'(win_reg[0]) + SUM_W'(mag);
    assign thr      = SUM_W'(WINDOW) * SUM_W'(mean_limit);

    // Flag hold and stall detection
    always_comb begin
        flag_next = flag_reg;
        cnt_next  = cnt_reg;
        trip      = 1'b0;
        if (flag_reg) begin
            if (cnt_reg < hold) begin
                cnt_next = cnt_reg + 8'd1;
            end else begin
                cnt_next  = 8'd0;
                flag_next = 1'b0;
            end
        end else if (sum_next > thr) begin
            flag_next = 1'b1;
            trip      = 1'b1;
        end
    end

    assign stat.trip = trip;
    assign stat.flag = flag_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) win_reg[i] <= '0;
            sum_reg  <= '0;
            flag_reg <= 1'b0;
            cnt_reg  <= 8'd0;
        end else if (advance) begin
            for (int i = 0; i < WINDOW - 1; i++) win_reg[i] <= win_reg[i+1];
            win_reg[WINDOW-1] <= mag;
            sum_reg  <= sum_next;
            flag_reg <= flag_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

FILE: rtl/fshg_heat_gate.sv
// Heat source select, local heat cooling, fire counter and shot gate.
module fshg_heat_gate (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  fshg_pkg::cfg_t       cfg,
    input  logic [1:0]           shot_request,
    input  logic [7:0]           shot_period,
    input  logic                 referee_present,
    input  logic [15:0]          referee_heat,
    input  logic                 stall_now,
    input  logic                 perr_small,
    output fshg_pkg::heat_stat_t stat
);
    logic [9:0]  heat_reg, heat_next;
    logic [9:0]  heat_cooled;
    logic [10:0] heat_raised;
    logic [7:0]  cool_cnt_reg, cool_cnt_next;
    logic [7:0]  fire_cnt_reg, fire_cnt_next;
    logic [15:0] heat;
    logic        attempt;
    logic        gate_ok;
    logic        fired;

    // Cooling runs only on the local estimate
    always_comb begin
        cool_cnt_next = cool_cnt_reg;
        heat_cooled   = heat_reg;
        heat          = referee_heat;
        if (!referee_present) begin
            if (cool_cnt_reg < cfg.cool_interval) begin
                cool_cnt_next = cool_cnt_reg + 8'd1;
            end else begin
                cool_cnt_next = 8'd0;
                if (heat_reg >= 10'(cfg.cool_step)) begin
                    heat_cooled = heat_reg - 10'(cfg.cool_step);
                end
            end
            heat = 16'(heat_cooled);
        end
    end

    // Shot attempt: single, or continuous fire on counter wrap
    always_comb begin
        fire_cnt_next = fire_cnt_reg;
        attempt       = 1'b0;
        case (shot_request)
            fshg_pkg::REQ_SINGLE: begin
                attempt = 1'b1;
            end
            fshg_pkg::REQ_CONTINUOUS: begin
                if (fire_cnt_reg < shot_period) begin
                    fire_cnt_next = fire_cnt_reg + 8'd1;
                end else begin
                    fire_cnt_next = 8'd0;
                    attempt       = 1'b1;
                end
            end
            default: begin
                attempt = 1'b0;
            end
        endcase
    end

    // ceiling - heat >= reserve, evaluated without wrap
    assign gate_ok = ({1'b0, heat} + {1'b0, cfg.heat_reserve}) <= {1'b0, cfg.heat_ceiling};
    assign fired   = attempt && !stall_now && gate_ok && perr_small;

    // Local heat rises per shot, saturating
    assign heat_raised = {1'b0, heat_cooled} + 11'(cfg.heat_per_shot);
    always_comb begin
        heat_next = heat_cooled;
        if (fired) begin
            heat_next = heat_raised[10] ? fshg_pkg::LOCAL_HEAT_MAX : heat_raised[9:0];
        end
    end

    assign stat.fired = fired;
    assign stat.heat  = heat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heat_reg     <= 10'd0;
            cool_cnt_reg <= 8'd0;
            fire_cnt_reg <= 8'd0;
        end else if (advance) begin
            heat_reg     <= heat_next;
            cool_cnt_reg <= cool_cnt_next;
            fire_cnt_reg <= fire_cnt_next;
        end
    end

endmodule

FILE: bench/feeder_stall_and_heat_gate_tb.sv
// Self-checking bench for the feeder stall detector and heat-gated shot stepper.
`timescale 1ns / 100ps

module feeder_stall_and_heat_gate_tb;

    localparam int     CLK_HALF     = 6;
    localparam int     WIN          = 10;
    localparam longint SHOT_STEP    = 235930;   // 3.6 units in Q16.16
    localparam longint REVERSE_STEP = 117965;   // 1.8 units in Q16.16
    localparam int     HEAT_SAT     = 1023;
    localparam int     TIMEOUT_NS   = 6_000_000;
    localparam logic [1:0] REQ_NONE    = 2'd0;
    localparam logic [1:0] REQ_REVERSE = 2'd3;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [143:0]                    s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [55:0]                     m_tdata;
    logic                            cfg_we    = 1'b0;
    logic [fshg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fshg_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow state of the block
    logic signed [15:0] cur_win [WIN];
    int unsigned        mag_sum;
    logic               stall_on;
    int unsigned        stall_cnt;
    int unsigned        fire_cnt;
    int unsigned        heat_est;
    int unsigned        cool_cnt;
    fshg_pkg::cfg_t     gate_cfg;

    fshg_pkg::s_item_t tick_inputs_q[$];
    fshg_pkg::m_item_t tick_results_q[$];
    int      n_queued   = 0;
    int      n_checked  = 0;
    int      mismatches = 0;
    bit      bursty     = 1'b0;
    bit      in_taken   = 1'b0;
    int      in_gap     = 0;
    int      out_stall  = 0;

    feeder_stall_and_heat_gate #(.WINDOW(WIN)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    function automatic int unsigned abs_current(logic signed [15:0] v);
        return (v < 0) ? -int'(v) : int'(v);
    endfunction

    function automatic logic [31:0] clamp_q16(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // One control tick: window sum, stall hold, heat source, shot gate
    function automatic fshg_pkg::m_item_t predict_tick(fshg_pkg::s_item_t it);
        fshg_pkg::m_item_t r;
        longint  perr_abs;
        int unsigned heat;
        bit      attempt;
        r = '0;
        r.setpoint_out = it.setpoint_now;
        attempt = 1'b0;

        mag_sum = mag_sum - abs_current(cur_win[0]);
        for (int i = 0; i < WIN - 1; i++) cur_win[i] = cur_win[i + 1];
        cur_win[WIN - 1] = it.current_sample;
        mag_sum = mag_sum + abs_current(it.current_sample);

        if (stall_on) begin
            if (stall_cnt < gate_cfg.stall_hold) begin
                stall_cnt++;
            end else begin
                stall_cnt = 0;
                stall_on  = 1'b0;
            end
        end else if (longint'(mag_sum) >
                     longint'(WIN) * longint'(gate_cfg.stall_mean_limit)) begin
            r.setpoint_out   = clamp_q16(longint'(it.position) - REVERSE_STEP);
            r.setpoint_write = 1'b1;
            stall_on         = 1'b1;
        end

        // local estimate cools only while the referee value is absent
        if (!it.referee_present) begin
            if (cool_cnt < gate_cfg.cool_interval) begin
                cool_cnt++;
            end else begin
                cool_cnt = 0;
                if (heat_est >= gate_cfg.cool_step) heat_est = heat_est - gate_cfg.cool_step;
            end
            heat = heat_est;
        end else begin
            heat = it.referee_heat;
        end

        case (it.shot_request)
            fshg_pkg::REQ_SINGLE: attempt = 1'b1;
            fshg_pkg::REQ_CONTINUOUS: begin
                if (fire_cnt < it.shot_period) begin
                    fire_cnt++;
                end else begin
                    fire_cnt = 0;
                    attempt  = 1'b1;
                end
            end
            default: ;
        endcase

        perr_abs = (it.position_error < 0) ? -longint'(it.position_error)
                                           : longint'(it.position_error);
        if (attempt && !stall_on && perr_abs < SHOT_STEP &&
            longint'(gate_cfg.heat_ceiling) - longint'(heat) >=
            longint'(gate_cfg.heat_reserve)) begin
            r.setpoint_out   = clamp_q16(longint'(it.setpoint_now) + SHOT_STEP);
            r.setpoint_write = 1'b1;
            r.shot_fired     = 1'b1;
            heat_est = heat_est + gate_cfg.heat_per_shot;
            if (heat_est > HEAT_SAT) heat_est = HEAT_SAT;
        end

        r.stall_locked = stall_on;
        r.heat_in_use  = heat[15:0];
        return r;
    endfunction

    function automatic fshg_pkg::s_item_t mk_tick(logic [15:0] cur, logic [31:0] pos,
                                                  logic [31:0] perr, logic [31:0] sp,
                                                  logic [1:0] req, logic [7:0] per,
                                                  logic refp, logic [15:0] rheat);
        fshg_pkg::s_item_t it;
        it = '0;
        it.current_sample  = cur;
        it.position        = pos;
        it.position_error  = perr;
        it.setpoint_now    = sp;
        it.shot_request    = req;
        it.shot_period     = per;
        it.referee_present = refp;
        it.referee_heat    = rheat;
        return it;
    endfunction

    // Q16.16 value, now and then close to either end of the range
    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF - $urandom_range(0, 300000);
            1:       return 32'h8000_0000 + $urandom_range(0, 300000);
            default: return $urandom();
        endcase
    endfunction

    task automatic push_tick(fshg_pkg::s_item_t it);
        tick_inputs_q.push_back(it);
        n_queued++;
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic set_reg(fshg_pkg::cfg_idx_t idx, int unsigned val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[fshg_pkg::CFG_DATA_W-1:0];
        case (idx)
            fshg_pkg::CFG_STALL_MEAN_LIMIT: gate_cfg.stall_mean_limit = val[14:0];
            fshg_pkg::CFG_STALL_HOLD:       gate_cfg.stall_hold       = val[7:0];
            fshg_pkg::CFG_HEAT_CEILING:     gate_cfg.heat_ceiling     = val[15:0];
            fshg_pkg::CFG_HEAT_RESERVE:     gate_cfg.heat_reserve     = val[15:0];
            fshg_pkg::CFG_HEAT_PER_SHOT:    gate_cfg.heat_per_shot    = val[7:0];
            fshg_pkg::CFG_COOL_STEP:        gate_cfg.cool_step        = val[7:0];
            fshg_pkg::CFG_COOL_INTERVAL:    gate_cfg.cool_interval    = val[7:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_cfg(int unsigned lim, int unsigned hold, int unsigned ceil,
                            int unsigned rsv, int unsigned hps, int unsigned cstep,
                            int unsigned cint);
        set_reg(fshg_pkg::CFG_STALL_MEAN_LIMIT, lim);
        set_reg(fshg_pkg::CFG_STALL_HOLD, hold);
        set_reg(fshg_pkg::CFG_HEAT_CEILING, ceil);
        set_reg(fshg_pkg::CFG_HEAT_RESERVE, rsv);
        set_reg(fshg_pkg::CFG_HEAT_PER_SHOT, hps);
        set_reg(fshg_pkg::CFG_COOL_STEP, cstep);
        set_reg(fshg_pkg::CFG_COOL_INTERVAL, cint);
    endtask

    task automatic wait_idle();
        while (n_checked != n_queued) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // Random ticks in runs: quiet motor, jammed motor, or raw noise
    task automatic queue_random(int count);
        fshg_pkg::s_item_t it;
        int      run_left;
        int      cur_mode;
        int      mag_v;
        int      pick;
        bit      use_ref;
        run_left = 0;
        cur_mode = 0;
        use_ref  = 1'b0;
        for (int k = 0; k < count; k++) begin
            if (run_left == 0) begin
                cur_mode = $urandom_range(0, 2);
                run_left = $urandom_range(5, 30);
            end
            run_left--;
            if ($urandom_range(0, 19) == 0) use_ref = ~use_ref;
            it = '0;
            case (cur_mode)
                0: it.current_sample = $urandom_range(0, 4000) - 2000;
                1: begin
                    mag_v = ($urandom_range(0, 5) == 0) ? 32768 : $urandom_range(18000, 32768);
                    it.current_sample = ($urandom_range(0, 1) == 1) ? -mag_v : mag_v;
                end
                default: it.current_sample = $urandom();
            endcase
            it.position     = rand_q16();
            it.setpoint_now = rand_q16();
            pick = $urandom_range(0, 19);
            if (pick < 4)       it.position_error = $urandom();
            else if (pick == 4) it.position_error = ($urandom_range(0, 1) == 1) ? 235930 : -235930;
            else if (pick == 5) it.position_error = ($urandom_range(0, 1) == 1) ? 235929 : -235929;
            else                it.position_error = $urandom_range(0, 480000) - 240000;
            pick = $urandom_range(0, 9);
            if (pick < 4)      it.shot_request = fshg_pkg::REQ_SINGLE;
            else if (pick < 7) it.shot_request = fshg_pkg::REQ_CONTINUOUS;
            else if (pick < 9) it.shot_request = REQ_NONE;
            else               it.shot_request = REQ_REVERSE;
            it.shot_period = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 4);
            it.referee_present = use_ref;
            it.referee_heat = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                              : $urandom_range(0, int'(gate_cfg.heat_ceiling) + 64);
            push_tick(it);
        end
    endtask

    // Input driver: inputs move on the falling edge
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (in_gap > 0) begin
                in_gap   <= in_gap - 1;
                s_tvalid <= 1'b0;
            end else if (tick_inputs_q.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= tick_inputs_q.pop_front();
                if (bursty && $urandom_range(0, 4) == 0) in_gap <= $urandom_range(1, 13);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result backpressure
    always @(negedge aclk) begin
        if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (bursty && $urandom_range(0, 5) == 0) out_stall <= $urandom_range(1, 13);
        end
    end

    // Predict on every accepted input transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) tick_results_q.push_back(predict_tick(s_tdata));
        end
    end

    // Compare each accepted result transaction with the oldest prediction
    always @(posedge aclk) begin
        fshg_pkg::m_item_t got;
        fshg_pkg::m_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (tick_results_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
            end else begin
                want = tick_results_q.pop_front();
                check_field("setpoint_out", want.setpoint_out, got.setpoint_out);
                check_field("setpoint_write", want.setpoint_write, got.setpoint_write);
                check_field("stall_locked", want.stall_locked, got.stall_locked);
                check_field("shot_fired", want.shot_fired, got.shot_fired);
                check_field("heat_in_use", want.heat_in_use, got.heat_in_use);
            end
            n_checked++;
        end
    end

    initial begin
        foreach (cur_win[i]) cur_win[i] = '0;
        mag_sum   = 0;
        stall_on  = 1'b0;
        stall_cnt = 0;
        fire_cnt  = 0;
        heat_est  = 0;
        cool_cnt  = 0;
        gate_cfg.stall_mean_limit = 15'd9500;
        gate_cfg.stall_hold       = 8'd25;
        gate_cfg.heat_ceiling     = 16'd320;
        gate_cfg.heat_reserve     = 16'd50;
        gate_cfg.heat_per_shot    = 8'd10;
        gate_cfg.cool_step        = 8'd10;
        gate_cfg.cool_interval    = 8'd25;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed ticks at reset defaults
        push_tick(mk_tick(16'd0, 32'd0, 32'd0, 32'd0, REQ_NONE, 8'd0, 1'b0, 16'd0));
        push_tick(mk_tick(16'd100, 32'h0001_0000, 32'd0, 32'h0010_0000,
                          fshg_pkg::REQ_SINGLE, 8'd0, 1'b0, 16'd0));
        // position error just inside, at, and far outside the shot window
        push_tick(mk_tick(-16'sd100, 32'd0, 32'd235929, 32'd5,
                          fshg_pkg::REQ_SINGLE, 8'd0, 1'b0, 16'd0));
        push_tick(mk_tick(16'd0, 32'd0, 32'd235930, 32'd5,
                          fshg_pkg::REQ_SINGLE, 8'd0, 1'b0, 16'd0));
        push_tick(mk_tick(16'd0, 32'd0, -32'sd235929, 32'd5,
                          fshg_pkg::REQ_SINGLE, 8'd0, 1'b0, 16'd0));
        push_tick(mk_tick(16'd0, 32'd0, 32'h8000_0000, 32'd5,
                          fshg_pkg::REQ_SINGLE, 8'd0, 1'b0, 16'd0));
        push_tick(mk_tick(16'd0, 32'd0, 32'h7FFF_FFFF, 32'd5,
                          fshg_pkg::REQ_SINGLE, 8'd0, 1'b0, 16'd0));
        // forward step saturates at the top of the range
        push_tick(mk_tick(16'd0, 32'd0, 32'd0, 32'h7FFF_FFFF,
                          fshg_pkg::REQ_SINGLE, 8'd0, 1'b0, 16'd0));
        // reverse code acts as no request
        push_tick(mk_tick(16'd0, 32'd0, 32'd0, 32'd7, REQ_REVERSE, 8'd0, 1'b0, 16'd0));
        // continuous fire with period zero, then period two, then period 255
        push_tick(mk_tick(16'd0, 32'd0, 32'd0, 32'd7,
                          fshg_pkg::REQ_CONTINUOUS, 8'd0, 1'b0, 16'd0));
        for (int k = 0; k < 4; k++)
            push_tick(mk_tick(16'd0, 32'd0, 32'd0, 32'd7,
                              fshg_pkg::REQ_CONTINUOUS, 8'd2, 1'b0, 16'd0));
        push_tick(mk_tick(16'd0, 32'd0, 32'd0, 32'd7,
                          fshg_pkg::REQ_CONTINUOUS, 8'd255, 1'b0, 16'd0));
        // referee heat: far above ceiling, exactly at reserve, one past it
        push_tick(mk_tick(16'd0, 32'd0, 32'd0, 32'd9,
                          fshg_pkg::REQ_SINGLE, 8'd0, 1'b1, 16'hFFFF));
        push_tick(mk_tick(16'd0, 32'd0, 32'd0, 32'd9,
                          fshg_pkg::REQ_SINGLE, 8'd0, 1'b1, 16'd270));
        push_tick(mk_tick(16'd0, 32'd0, 32'd0, 32'd9,
                          fshg_pkg::REQ_SINGLE, 8'd0, 1'b1, 16'd271));
        // jammed motor trips the stall; reverse saturates at the bottom
        push_tick(mk_tick(16'h7FFF, 32'h8000_0005, 32'd0, 32'd9, REQ_NONE, 8'd0, 1'b0, 16'd0));
        push_tick(mk_tick(16'h8000, 32'h8000_0005, 32'd0, 32'd9, REQ_NONE, 8'd0, 1'b0, 16'd0));
        push_tick(mk_tick(16'h7FFF, 32'h8000_0005, 32'd0, 32'd9, REQ_NONE, 8'd0, 1'b0, 16'd0));
        // shot refused while stalled
        push_tick(mk_tick(16'h8000, 32'd0, 32'd0, 32'd9,
                          fshg_pkg::REQ_SINGLE, 8'd0, 1'b0, 16'd0));
        wait_idle();

        // Random phases: defaults, both extremes, then random settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: ;
                1: load_cfg(0, 0, 65535, 0, 255, 255, 0);
                2: load_cfg(32767, 255, 0, 65535, 0, 0, 255);
                default: load_cfg($urandom_range(1000, 20000), $urandom_range(0, 40),
                                  $urandom_range(100, 1200), $urandom_range(0, 200),
                                  $urandom_range(0, 40), $urandom_range(0, 30),
                                  $urandom_range(0, 30));
            endcase
            bursty = (ph == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
            queue_random(ph == 2 ? 80 : 145);
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (tick_results_q.size() != 0) begin
            mismatches++;
            $display("%0t: results missing, expected %0d more, got none", $time,
                     tick_results_q.size());
        end
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule

FILE: feeder_stall_and_heat_gate.f
rtl/fshg_pkg.sv
rtl/fshg_stall_det.sv
rtl/fshg_heat_gate.sv
rtl/feeder_stall_and_heat_gate.sv
bench/feeder_stall_and_heat_gate_tb.sv
